FILE: design/ccvg_pkg.sv
// Shared types and constants for the character cell video generator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package ccvg_pkg;

    localparam int CMD_W             = 3;
    localparam int ADDR_W            = 10;
    localparam int DATA_W            = 8;
    localparam int PIX_W             = 8;
    localparam int LINE_W            = 3;
    localparam int SCREEN_CELLS_DEF  = 768;
    localparam int PATTERN_BYTES_DEF = 1024;
    localparam int COLUMNS           = 32;
    localparam int COL_BITS          = $clog2(COLUMNS);
    localparam int INV_BIT           = 7;

    localparam logic [LINE_W-1:0] LAST_LINE = 3'd7;

    localparam logic [CMD_W-1:0] CMD_WR_SCREEN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RD_SCREEN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_PATTERN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RD_PATTERN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REFRESH    = 3'd4;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    typedef enum logic [2:0] {
        OP_WR_SCREEN,
        OP_RD_SCREEN,
        OP_WR_PATTERN,
        OP_RD_PATTERN,
        OP_RD_ZERO,
        OP_REFRESH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } q_item_t;

endpackage

FILE: design/character_cell_video_generator_top.sv
// Top level of the character cell video generator: front end, queue and back end.
// Depends on ccvg_pkg, ccvg_front and ccvg_back.
//
//   Channel | Handshake            | Payload
//   input   | in_valid / in_ready   | command, address, write_data
//   output  | out_valid / out_ready | kind, read_data, pixel_row, pixel_x, pixel_y, is_last
//
// In the back end a write completes in the idle state, a read passes through
// a read state, and a dirty refresh does a screen read, then one pattern store
// read per row for eight rows. A clean refresh gives nothing; an out-of-range
// write or refresh and an undefined command are dropped by the front end.
// After reset a pass over all SCREEN_CELLS cells marks every cell dirty; in_ready
// stays low during it. A two-item queue parts the two ends, and the output
// register takes a new result in the cycle its previous one is taken.
`timescale 1ns / 1ps

module character_cell_video_generator_top #(
    parameter int SCREEN_CELLS  = ccvg_pkg::SCREEN_CELLS_DEF,
    parameter int PATTERN_BYTES = ccvg_pkg::PATTERN_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ccvg_pkg::CMD_W-1:0]    command,
    input  logic [ccvg_pkg::ADDR_W-1:0]   address,
    input  logic [ccvg_pkg::DATA_W-1:0]   write_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [ccvg_pkg::DATA_W-1:0]   read_data,
    output logic [ccvg_pkg::PIX_W-1:0]    pixel_row,
    output logic [ccvg_pkg::PIX_W-1:0]    pixel_x,
    output logic [ccvg_pkg::PIX_W-1:0]    pixel_y,
    output logic                          is_last
);
    import ccvg_pkg::*;

    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;
    logic    clearing;

    ccvg_front #(
        .SCREEN_CELLS  (SCREEN_CELLS),
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .clearing   (clearing),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    ccvg_back #(
        .SCREEN_CELLS  (SCREEN_CELLS),
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .read_data (read_data),
        .pixel_row (pixel_row),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .is_last   (is_last)
    );

endmodule

FILE: design/ccvg_front.sv
// Front end: accepts bus items, decodes them and queues the ones with work.
// Depends on ccvg_pkg.
`timescale 1ns / 1ps

module ccvg_front #(
    parameter int SCREEN_CELLS  = ccvg_pkg::SCREEN_CELLS_DEF,
    parameter int PATTERN_BYTES = ccvg_pkg::PATTERN_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ccvg_pkg::CMD_W-1:0]    command,
    input  logic [ccvg_pkg::ADDR_W-1:0]   address,
    input  logic [ccvg_pkg::DATA_W-1:0]   write_data,
    input  logic                          clearing,
    output logic                          q_valid,
    output ccvg_pkg::q_item_t             q_item,
    input  logic                          q_pop
);
    import ccvg_pkg::*;

    localparam int Q_DEPTH = 2;

    q_item_t     entry_reg [Q_DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        keep;
    op_t         dec_op;
    logic        in_scr;
    logic        in_pat;
    logic        push;

    assign in_scr = (32'(address) < 32'(SCREEN_CELLS));
    assign in_pat = (32'(address) < 32'(PATTERN_BYTES));

    always_comb
    begin
        keep   = 1'b0;
        dec_op = OP_RD_ZERO;
        unique case (command)
            CMD_WR_SCREEN:
            begin
                keep   = in_scr;
                dec_op = OP_WR_SCREEN;
            end
            CMD_RD_SCREEN:
            begin
                keep   = 1'b1;
                dec_op = in_scr ? OP_RD_SCREEN : OP_RD_ZERO;
            end
            CMD_WR_PATTERN:
            begin
                keep   = in_pat;
                dec_op = OP_WR_PATTERN;
            end
            CMD_RD_PATTERN:
            begin
                keep   = 1'b1;
                dec_op = in_pat ? OP_RD_PATTERN : OP_RD_ZERO;
            end
            CMD_REFRESH:
            begin
                keep   = in_scr;
                dec_op = OP_REFRESH;
            end
            default:
            begin
                keep   = 1'b0;
                dec_op = OP_RD_ZERO;
            end
        endcase
    end

    assign in_ready   = !clearing && (count_reg != 2'(Q_DEPTH));
    assign push       = in_valid && in_ready && keep;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = entry_reg[rd_ptr_reg];
    assign count_next = count_reg + 2'(push) - 2'(q_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= '{op: dec_op, addr: address, data: write_data};
    end

endmodule

FILE: design/ccvg_back.sv
// Back end: owns the screen and pattern stores, executes queued items and
// drives the result register. Depends on ccvg_pkg.
`timescale 1ns / 1ps

module ccvg_back #(
    parameter int SCREEN_CELLS  = ccvg_pkg::SCREEN_CELLS_DEF,
    parameter int PATTERN_BYTES = ccvg_pkg::PATTERN_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  ccvg_pkg::q_item_t             q_item,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [ccvg_pkg::DATA_W-1:0]   read_data,
    output logic [ccvg_pkg::PIX_W-1:0]    pixel_row,
    output logic [ccvg_pkg::PIX_W-1:0]    pixel_x,
    output logic [ccvg_pkg::PIX_W-1:0]    pixel_y,
    output logic                          is_last
);
    import ccvg_pkg::*;

    localparam int SCR_AW = $clog2(SCREEN_CELLS);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int EXT_A  = (SCR_AW > ADDR_W) ? SCR_AW : ADDR_W;
    localparam int EXT_W  = (PAT_AW > EXT_A) ? PAT_AW : EXT_A;
    localparam int PIDX_W = 12;
    localparam int SCR_W  = DATA_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_REF_CODE,
        S_REF_ROW
    } state_t;

    // Each screen word holds the dirty bit above the character code.
    logic [SCR_W-1:0]  scr_mem [SCREEN_CELLS];
    logic [DATA_W-1:0] pat_mem [PATTERN_BYTES];
    logic [SCR_W-1:0]  scr_q_reg;
    logic [DATA_W-1:0] pat_q_reg;

    state_t            state_reg,     state_next;
    op_t               cur_op_reg,    cur_op_next;
    logic [ADDR_W-1:0] cur_addr_reg,  cur_addr_next;
    logic [DATA_W-1:0] code_reg,      code_next;
    logic [LINE_W-1:0] line_reg,      line_next;
    logic [SCR_AW-1:0] clr_cnt_reg,   clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg,      kind_next;
    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic [PIX_W-1:0]  pixel_row_reg, pixel_row_next;
    logic [PIX_W-1:0]  pixel_x_reg,   pixel_x_next;
    logic [PIX_W-1:0]  pixel_y_reg,   pixel_y_next;
    logic              is_last_reg,   is_last_next;

    logic              scr_we;
    logic [SCR_AW-1:0] scr_waddr;
    logic [SCR_W-1:0]  scr_wdata;
    logic [SCR_AW-1:0] scr_raddr;
    logic              pat_we;
    logic [PAT_AW-1:0] pat_waddr;
    logic [PAT_AW-1:0] pat_raddr;
    logic              out_free;

    function automatic logic [SCR_AW-1:0] scr_idx(input logic [ADDR_W-1:0] a);
        logic [EXT_W-1:0] e;
        e = EXT_W'(a);
        return e[SCR_AW-1:0];
    endfunction

    function automatic logic [PAT_AW-1:0] pat_idx(input logic [ADDR_W-1:0] a);
        logic [EXT_W-1:0] e;
        e = EXT_W'(a);
        return e[PAT_AW-1:0];
    endfunction

    // Glyph row address, wrapped into the pattern store.
    function automatic logic [PAT_AW-1:0] row_idx(input logic [DATA_W-1:0] code,
                                                  input logic [LINE_W-1:0] line);
        logic [PIDX_W-1:0] v;
        v = PIDX_W'({code[DATA_W-2:0], line});
        for (int i = 0; i < 4; i++)
        begin
            if (v >= PIDX_W'(PATTERN_BYTES))
                v = v - PIDX_W'(PATTERN_BYTES);
        end
        return v[PAT_AW-1:0];
    endfunction

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cur_op_next    = cur_op_reg;
        cur_addr_next  = cur_addr_reg;
        code_next      = code_reg;
        line_next      = line_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        read_data_next = read_data_reg;
        pixel_row_next = pixel_row_reg;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        is_last_next   = is_last_reg;
        scr_we         = 1'b0;
        scr_waddr      = scr_idx(cur_addr_reg);
        scr_wdata      = '0;
        scr_raddr      = scr_idx(cur_addr_reg);
        pat_we         = 1'b0;
        pat_waddr      = pat_idx(q_item.addr);
        pat_raddr      = pat_idx(cur_addr_reg);
        q_pop          = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                scr_we       = 1'b1;
                scr_waddr    = clr_cnt_reg;
                scr_wdata    = {1'b1, {DATA_W{1'b0}}};
                clr_cnt_next = clr_cnt_reg + SCR_AW'(1);
                if (clr_cnt_reg == SCR_AW'(SCREEN_CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                scr_raddr = scr_idx(q_item.addr);
                pat_raddr = pat_idx(q_item.addr);
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cur_op_next   = q_item.op;
                    cur_addr_next = q_item.addr;
                    unique case (q_item.op)
                        OP_WR_SCREEN:
                        begin
                            scr_we    = 1'b1;
                            scr_waddr = scr_idx(q_item.addr);
                            scr_wdata = {1'b1, q_item.data};
                        end
                        OP_WR_PATTERN:
                            pat_we = 1'b1;
                        OP_RD_SCREEN, OP_RD_PATTERN, OP_RD_ZERO:
                            state_next = S_READ;
                        OP_REFRESH:
                            state_next = S_REF_CODE;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_READ;
                    pixel_row_next = '0;
                    pixel_x_next   = '0;
                    pixel_y_next   = '0;
                    is_last_next   = 1'b1;
                    if (cur_op_reg == OP_RD_SCREEN)
                        read_data_next = scr_q_reg[DATA_W-1:0];
                    else if (cur_op_reg == OP_RD_PATTERN)
                        read_data_next = pat_q_reg;
                    else
                        read_data_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_REF_CODE:
            begin
                if (scr_q_reg[DATA_W])
                begin
                    code_next  = scr_q_reg[DATA_W-1:0];
                    scr_we     = 1'b1;
                    scr_wdata  = {1'b0, scr_q_reg[DATA_W-1:0]};
                    line_next  = '0;
                    pat_raddr  = row_idx(scr_q_reg[DATA_W-1:0], '0);
                    state_next = S_REF_ROW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REF_ROW:
            begin
                pat_raddr = row_idx(code_reg, line_reg);
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ROW;
                    read_data_next = '0;
                    pixel_row_next = code_reg[INV_BIT] ? ~pat_q_reg : pat_q_reg;
                    pixel_x_next   = PIX_W'({cur_addr_reg[COL_BITS-1:0], {LINE_W{1'b0}}});
                    pixel_y_next   = PIX_W'({cur_addr_reg[ADDR_W-1:COL_BITS], line_reg});
                    is_last_next   = (line_reg == LAST_LINE);
                    line_next      = line_reg + LINE_W'(1);
                    pat_raddr      = row_idx(code_reg, line_reg + LINE_W'(1));
                    if (line_reg == LAST_LINE)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_op_reg    <= OP_RD_ZERO;
            cur_addr_reg  <= '0;
            code_reg      <= '0;
            line_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            read_data_reg <= '0;
            pixel_row_reg <= '0;
            pixel_x_reg   <= '0;
            pixel_y_reg   <= '0;
            is_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_op_reg    <= cur_op_next;
            cur_addr_reg  <= cur_addr_next;
            code_reg      <= code_next;
            line_reg      <= line_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            read_data_reg <= read_data_next;
            pixel_row_reg <= pixel_row_next;
            pixel_x_reg   <= pixel_x_next;
            pixel_y_reg   <= pixel_y_next;
            is_last_reg   <= is_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[scr_waddr] <= scr_wdata;
        scr_q_reg <= scr_mem[scr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[pat_waddr] <= q_item.data;
        pat_q_reg <= pat_mem[pat_raddr];
    end

    assign clearing  = (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign read_data = read_data_reg;
    assign pixel_row = pixel_row_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign is_last   = is_last_reg;

endmodule

FILE: design/ccvg_checker.sv
// Port-level checks for the character cell video generator, bound to the top.
// Depends on ccvg_pkg and character_cell_video_generator_top.
`timescale 1ns / 1ps

module ccvg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          kind,
    input logic [ccvg_pkg::DATA_W-1:0]   read_data,
    input logic [ccvg_pkg::PIX_W-1:0]    pixel_row,
    input logic [ccvg_pkg::PIX_W-1:0]    pixel_x,
    input logic [ccvg_pkg::PIX_W-1:0]    pixel_y,
    input logic                          is_last
);
    import ccvg_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(read_data)
            && $stable(pixel_row) && $stable(pixel_x) && $stable(pixel_y)
            && $stable(is_last))
        else $error("Stalled result changed.");

    a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_READ) |-> is_last && (pixel_row == '0)
            && (pixel_x == '0) && (pixel_y == '0))
        else $error("Read result carries pixel fields.");

    a_row_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ROW) |-> (read_data == '0)
            && (is_last == (pixel_y[LINE_W-1:0] == LAST_LINE)))
        else $error("Pixel row result has a bad last flag or read data.");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == KIND_ROW) && !is_last
            |=> out_valid && (kind == KIND_ROW))
        else $error("Pixel rows of a cell are not contiguous.");

endmodule

bind character_cell_video_generator_top ccvg_checker u_ccvg_checker (.*);
